>>> design/lcdq_pkg.sv
package lcdq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] UNIX_RESET = 32'd1662385700;
  localparam logic [7:0]  TPM_RESET  = 8'd10;
  localparam logic [7:0]  MPT_RESET  = 8'd100;
  localparam logic [7:0]  TPS_RESET  = 8'd10;

  localparam logic [2:0] ACT_TICK        = 3'd0;
  localparam logic [2:0] ACT_ENQUEUE     = 3'd1;
  localparam logic [2:0] ACT_SET_UNIX    = 3'd2;
  localparam logic [2:0] ACT_SET_BLOCK   = 3'd3;
  localparam logic [2:0] ACT_POLL_TENTH  = 3'd4;
  localparam logic [2:0] ACT_POLL_SECOND = 3'd5;

  localparam logic [1:0] CFG_TICKS_PER_MILLI   = 2'd0;
  localparam logic [1:0] CFG_MILLIS_PER_TENTH  = 2'd1;
  localparam logic [1:0] CFG_TENTHS_PER_SECOND = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic        select_flag;
    logic [7:0]  char_byte;
    logic [31:0] unix_value;
    logic [7:0]  block_seconds;
  } in_item_t;

  typedef struct packed {
    logic        lcd_rs;
    logic        lcd_en;
    logic [3:0]  lcd_nibble;
    logic [31:0] millis_count;
    logic [31:0] uptime_seconds;
    logic [31:0] unix_seconds;
    logic        polled_flag;
    logic        display_blocked;
  } out_item_t;

  typedef struct packed {
    logic [7:0] ticks_per_milli;
    logic [7:0] millis_per_tenth;
    logic [7:0] tenths_per_second;
  } cfg_regs_t;

  typedef struct packed {
    logic        tick;
    logic        set_unix;
    logic        set_block;
    logic        poll_tenth;
    logic        poll_second;
    logic [31:0] unix_value;
    logic [7:0]  block_seconds;
  } tb_ctrl_t;

  typedef struct packed {
    logic [31:0] millis_count;
    logic [31:0] uptime_seconds;
    logic [31:0] unix_seconds;
    logic        polled_flag;
    logic        display_blocked;
  } tb_stat_t;

  typedef struct packed {
    logic       enqueue;
    logic       step;
    logic       select_flag;
    logic [7:0] char_byte;
  } q_ctrl_t;

  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nibble;
  } lcd_pins_t;

  typedef struct packed {
    logic       select_flag;
    logic [7:0] char_byte;
  } q_entry_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HIGH   = 3'd1,
    PH_HIGH_W = 3'd2,
    PH_LOW    = 3'd3,
    PH_LOW_W  = 3'd4,
    PH_DONE   = 3'd5
  } seq_phase_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

>>> design/lcdq_ram.sv
module lcdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/lcdq_timebase.sv
module lcdq_timebase (
  input  logic                clk,
  input  logic                rst_n,
  input  lcdq_pkg::cfg_regs_t cfg,
  input  lcdq_pkg::tb_ctrl_t  ctrl,
  output logic                seq_step,
  output lcdq_pkg::tb_stat_t  stat
);

  logic [7:0]  tick_r, tick_nxt;
  logic [7:0]  milli_r, milli_nxt;
  logic [7:0]  tenth_r, tenth_nxt;
  logic [31:0] millis_r, millis_nxt;
  logic [31:0] uptime_r, uptime_nxt;
  logic [31:0] unix_r, unix_nxt;
  logic        tenth_flag_r, tenth_flag_nxt;
  logic        second_flag_r, second_flag_nxt;
  logic [7:0]  block_r, block_nxt;
  logic [7:0]  tick_inc, milli_inc, tenth_inc;
  logic        polled;

  always_comb begin
    tick_nxt        = tick_r;
    milli_nxt       = milli_r;
    tenth_nxt       = tenth_r;
    millis_nxt      = millis_r;
    uptime_nxt      = uptime_r;
    unix_nxt        = unix_r;
    tenth_flag_nxt  = tenth_flag_r;
    second_flag_nxt = second_flag_r;
    block_nxt       = block_r;
    polled          = 1'b0;
    seq_step        = 1'b0;
    tick_inc        = tick_r + 8'd1;
    milli_inc       = milli_r + 8'd1;
    tenth_inc       = tenth_r + 8'd1;

    if (ctrl.tick) begin
      if (tick_inc >= cfg.ticks_per_milli) begin
        tick_nxt   = '0;
        millis_nxt = millis_r + 32'd1;
        if (milli_inc < cfg.millis_per_tenth) begin
          milli_nxt = milli_inc;
        end else begin
          milli_nxt      = '0;
          tenth_flag_nxt = 1'b1;
          if (tenth_inc < cfg.tenths_per_second) begin
            tenth_nxt = tenth_inc;
          end else begin
            tenth_nxt       = '0;
            uptime_nxt      = uptime_r + 32'd1;
            unix_nxt        = unix_r + 32'd1;
            second_flag_nxt = 1'b1;
            if (block_r != 8'd0) begin
              block_nxt = block_r - 8'd1;
            end
          end
        end
      end else begin
        tick_nxt = tick_inc;
        seq_step = 1'b1;
      end
    end
    if (ctrl.set_unix) begin
      unix_nxt = ctrl.unix_value;
    end
    if (ctrl.set_block) begin
      block_nxt = ctrl.block_seconds;
    end
    if (ctrl.poll_tenth) begin
      polled         = tenth_flag_r;
      tenth_flag_nxt = 1'b0;
    end
    if (ctrl.poll_second) begin
      polled          = second_flag_r;
      second_flag_nxt = 1'b0;
    end

    stat.millis_count    = millis_nxt;
    stat.uptime_seconds  = uptime_nxt;
    stat.unix_seconds    = unix_nxt;
    stat.polled_flag     = polled;
    stat.display_blocked = (block_nxt != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r        <= '0;
      milli_r       <= '0;
      tenth_r       <= '0;
      millis_r      <= '0;
      uptime_r      <= '0;
      unix_r        <= lcdq_pkg::UNIX_RESET;
      tenth_flag_r  <= 1'b0;
      second_flag_r <= 1'b0;
      block_r       <= '0;
    end else begin
      tick_r        <= tick_nxt;
      milli_r       <= milli_nxt;
      tenth_r       <= tenth_nxt;
      millis_r      <= millis_nxt;
      uptime_r      <= uptime_nxt;
      unix_r        <= unix_nxt;
      tenth_flag_r  <= tenth_flag_nxt;
      second_flag_r <= second_flag_nxt;
      block_r       <= block_nxt;
    end
  end

endmodule

>>> design/lcdq_queue.sv
module lcdq_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  lcdq_pkg::q_ctrl_t   ctrl,
  output lcdq_pkg::lcd_pins_t pins
);

  logic [lcdq_pkg::PTR_W-1:0] wptr_r, wptr_nxt;
  logic [lcdq_pkg::PTR_W-1:0] rptr_r, rptr_nxt;
  lcdq_pkg::seq_phase_t       phase_r, phase_nxt;
  lcdq_pkg::lcd_pins_t        pins_r, pins_nxt;
  lcdq_pkg::q_entry_t         wr_entry, ram_q, rd_entry;
  lcdq_pkg::q_entry_t         byp_data_r;
  logic                       byp_r, byp_nxt;

  lcdq_ram #(
    .WIDTH($bits(lcdq_pkg::q_entry_t)),
    .DEPTH(lcdq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctrl.enqueue),
    .waddr(wptr_r),
    .wdata(wr_entry),
    .raddr(rptr_nxt),
    .rdata(ram_q)
  );

  // RAM returns old data when read and written at one address
  assign rd_entry = byp_r ? byp_data_r : ram_q;

  always_comb begin
    wptr_nxt             = wptr_r;
    rptr_nxt             = rptr_r;
    phase_nxt            = phase_r;
    pins_nxt             = pins_r;
    wr_entry.select_flag = ctrl.select_flag;
    wr_entry.char_byte   = ctrl.char_byte;

    if (ctrl.enqueue) begin
      wptr_nxt = lcdq_pkg::ring_next(wptr_r);
      if (wptr_nxt == rptr_r) begin
        rptr_nxt = lcdq_pkg::ring_next(rptr_r);
      end
    end

    if (ctrl.step) begin
      unique case (phase_r)
        lcdq_pkg::PH_IDLE: begin
          if (rptr_r != wptr_r) begin
            pins_nxt.rs = rd_entry.select_flag;
            pins_nxt.en = 1'b0;
            phase_nxt   = lcdq_pkg::PH_HIGH;
          end
        end
        lcdq_pkg::PH_HIGH: begin
          pins_nxt.en     = 1'b0;
          pins_nxt.nibble = rd_entry.char_byte[7:4];
          phase_nxt       = lcdq_pkg::PH_HIGH_W;
        end
        lcdq_pkg::PH_HIGH_W: begin
          pins_nxt.en = 1'b1;
          phase_nxt   = lcdq_pkg::PH_LOW;
        end
        lcdq_pkg::PH_LOW: begin
          pins_nxt.en     = 1'b0;
          pins_nxt.nibble = rd_entry.char_byte[3:0];
          phase_nxt       = lcdq_pkg::PH_LOW_W;
        end
        lcdq_pkg::PH_LOW_W: begin
          pins_nxt.en = 1'b1;
          phase_nxt   = lcdq_pkg::PH_DONE;
        end
        default: begin
          pins_nxt.en = 1'b0;
          pins_nxt.rs = 1'b0;
          rptr_nxt    = lcdq_pkg::ring_next(rptr_r);
          phase_nxt   = lcdq_pkg::PH_IDLE;
        end
      endcase
    end

    byp_nxt = ctrl.enqueue && (wptr_r == rptr_nxt);
  end

  assign pins = pins_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      phase_r <= lcdq_pkg::PH_IDLE;
      pins_r  <= '0;
      byp_r   <= 1'b0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      phase_r <= phase_nxt;
      pins_r  <= pins_nxt;
      byp_r   <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= wr_entry;
  end

endmodule

>>> design/lcd_nibble_queue_timebase.sv
// Channel | Direction | Handshake              | Payload
// in_     | input     | in_valid / in_ready    | in_data  (lcdq_pkg::in_item_t)
// out_    | output    | out_valid / out_ready  | out_data (lcdq_pkg::out_item_t)
// cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One transaction per clock sustained unless the output stalls; each result leaves
// the output register after the input register and the single update pass. The
// queue RAM read is prefetched at the next read pointer, so the current entry is
// already at the RAM output. cfg_ready is always high. Synchronous active-low reset
// clears control and counters, but loads the Unix seconds with UNIX_RESET and cfg
// with defaults; the queue RAM needs no clearing pass. A stalled output holds its
// result and the input register takes one more transaction before in_ready drops.
module lcd_nibble_queue_timebase (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lcdq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lcdq_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  lcdq_pkg::in_item_t  inq_r;
  logic                inq_valid_r;
  lcdq_pkg::out_item_t out_data_r, res;
  logic                out_valid_r;
  logic                have_r;
  lcdq_pkg::cfg_regs_t cfg_r;
  lcdq_pkg::tb_ctrl_t  tb_ctrl;
  lcdq_pkg::tb_stat_t  tb_stat;
  lcdq_pkg::q_ctrl_t   q_ctrl;
  lcdq_pkg::lcd_pins_t pins;
  logic                seq_step;
  logic                proc_fire;

  assign proc_fire = inq_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !inq_valid_r || proc_fire;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    tb_ctrl.tick          = proc_fire && (inq_r.action == lcdq_pkg::ACT_TICK);
    tb_ctrl.set_unix      = proc_fire && (inq_r.action == lcdq_pkg::ACT_SET_UNIX);
    tb_ctrl.set_block     = proc_fire && (inq_r.action == lcdq_pkg::ACT_SET_BLOCK);
    tb_ctrl.poll_tenth    = proc_fire && (inq_r.action == lcdq_pkg::ACT_POLL_TENTH);
    tb_ctrl.poll_second   = proc_fire && (inq_r.action == lcdq_pkg::ACT_POLL_SECOND);
    tb_ctrl.unix_value    = inq_r.unix_value;
    tb_ctrl.block_seconds = inq_r.block_seconds;

    q_ctrl.enqueue     = proc_fire && (inq_r.action == lcdq_pkg::ACT_ENQUEUE);
    q_ctrl.step        = seq_step;
    q_ctrl.select_flag = inq_r.select_flag;
    q_ctrl.char_byte   = inq_r.char_byte;

    res.lcd_rs          = pins.rs;
    res.lcd_en          = pins.en;
    res.lcd_nibble      = pins.nibble;
    res.millis_count    = tb_stat.millis_count;
    res.uptime_seconds  = tb_stat.uptime_seconds;
    res.unix_seconds    = tb_stat.unix_seconds;
    res.polled_flag     = tb_stat.polled_flag;
    res.display_blocked = tb_stat.display_blocked;
  end

  lcdq_timebase u_timebase (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .ctrl    (tb_ctrl),
    .seq_step(seq_step),
    .stat    (tb_stat)
  );

  lcdq_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (q_ctrl),
    .pins (pins)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
      cfg_r.ticks_per_milli   <= lcdq_pkg::TPM_RESET;
      cfg_r.millis_per_tenth  <= lcdq_pkg::MPT_RESET;
      cfg_r.tenths_per_second <= lcdq_pkg::TPS_RESET;
    end else begin
      if (in_valid && in_ready) begin
        inq_valid_r <= 1'b1;
      end else if (proc_fire) begin
        inq_valid_r <= 1'b0;
      end
      if (proc_fire) begin
        out_valid_r <= 1'b1;
        have_r      <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lcdq_pkg::CFG_TICKS_PER_MILLI:   cfg_r.ticks_per_milli   <= cfg_data;
          lcdq_pkg::CFG_MILLIS_PER_TENTH:  cfg_r.millis_per_tenth  <= cfg_data;
          lcdq_pkg::CFG_TENTHS_PER_SECOND: cfg_r.tenths_per_second <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_r <= in_data;
    end
    if (proc_fire) begin
      out_data_r <= res;
    end
  end

  a_millis_step: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && have_r |->
      (res.millis_count == out_data_r.millis_count) ||
      (res.millis_count == out_data_r.millis_count + 32'd1))
    else $error("millisecond count moved by more than one");

  a_uptime_on_milli: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && have_r && (res.uptime_seconds != out_data_r.uptime_seconds) |->
      (res.millis_count != out_data_r.millis_count))
    else $error("uptime advanced without a millisecond step");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    inq_valid_r && !proc_fire |=> inq_valid_r && $stable(inq_r))
    else $error("pending input transaction lost");

endmodule
